### rtl/tfp_pkg.sv
// ----------------------------------------------------------------------------
// tfp_pkg
// Shared types and codes for the TLV frame parser.
// ----------------------------------------------------------------------------
package tfp_pkg;

    localparam int TFP_TAG_COUNT = 256;

    // Op codes of an input request
    localparam logic OP_TABLE = 1'b0;
    localparam logic OP_BYTE  = 1'b1;

    // Parse phases; the byte kind reported uses the same encoding
    localparam logic [2:0] PH_MSG = 3'd0;
    localparam logic [2:0] PH_VER = 3'd1;
    localparam logic [2:0] PH_TAG = 3'd2;
    localparam logic [2:0] PH_LEN = 3'd3;
    localparam logic [2:0] PH_VAL = 3'd4;

    // Frame status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FMT  = 2'd1;
    localparam logic [1:0] ST_SIZE = 2'd2;

    typedef logic [2:0] t_phase;

    typedef struct packed {
        logic [2:0] byte_kind;
        logic [7:0] byte_out;
        logic [7:0] record_tag;
        logic [7:0] value_position;
        logic       record_complete;
        logic       delivered;
        logic       frame_done;
        logic [1:0] frame_status;
    } t_result;

endpackage

### rtl/tfp_ifs.sv
// ----------------------------------------------------------------------------
// tfp_ifs
// Valid/ready channels of the TLV frame parser.
// ----------------------------------------------------------------------------
interface tlv_in_if;
    logic       valid;
    logic       ready;
    logic       op;
    logic [7:0] table_tag;
    logic [7:0] table_size;
    logic [7:0] data_byte;
    logic       frame_last;

    modport source (output valid, op, table_tag, table_size, data_byte, frame_last,
                    input ready);
    modport sink   (input valid, op, table_tag, table_size, data_byte, frame_last,
                    output ready);
endinterface

interface tlv_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] byte_kind;
    logic [7:0] byte_out;
    logic [7:0] record_tag;
    logic [7:0] value_position;
    logic       record_complete;
    logic       delivered;
    logic       frame_done;
    logic [1:0] frame_status;

    modport source (output valid, byte_kind, byte_out, record_tag, value_position,
                    record_complete, delivered, frame_done, frame_status,
                    input ready);
    modport sink   (input valid, byte_kind, byte_out, record_tag, value_position,
                    record_complete, delivered, frame_done, frame_status,
                    output ready);
endinterface

### rtl/tfp_ram.sv
// ----------------------------------------------------------------------------
// tfp_ram
// Generic single-write, single-read RAM with registered read (old data on
// read-during-write).
// ----------------------------------------------------------------------------
module tfp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_q <= r_mem[i_raddr];
    end

    assign o_rdata = r_q;
endmodule

### rtl/tlv_frame_parser.sv
// ----------------------------------------------------------------------------
// tlv_frame_parser
// Streaming parser for message/version header plus tag-length-value records.
//
//   channel | dir | payload
//   i_in    | in  | op, table_tag, table_size, data_byte, frame_last
//   o_out   | out | byte_kind, byte_out, record_tag, value_position,
//           |     | record_complete, delivered, frame_done, frame_status
//
// One request per cycle while i_in.ready is high; byte results are registered.
// The expected-length RAM is addressed by the next record tag, so its
// registered read is ready for the length byte; a table write to that tag is
// bypassed. Reset clears parse state and the per-entry valid bits at once.
// A two-entry output buffer keeps i_in.ready high while one result waits.
// ----------------------------------------------------------------------------
module tlv_frame_parser #(
    parameter int TAG_COUNT = tfp_pkg::TFP_TAG_COUNT
) (
    input logic      i_clk,
    input logic      i_rst_n,
    tlv_in_if.sink   i_in,
    tlv_out_if.source o_out
);
    import tfp_pkg::*;

    localparam int TAG_AW = $clog2(TAG_COUNT);

    t_phase      r_phase, n_phase;
    logic [7:0]  r_tag, n_tag;
    logic [7:0]  r_rem, n_rem;
    logic [7:0]  r_cnt, n_cnt;
    logic        r_err, n_err;

    logic                 r_tvld [TAG_COUNT];
    logic                 r_hit;
    logic [7:0]           r_hit_data;
    logic                 r_rvld;
    logic [7:0]           ram_q;
    logic [7:0]           expect_len;
    logic                 tbl_we;
    logic [TAG_AW-1:0]    tbl_waddr;
    logic [TAG_AW-1:0]    tbl_raddr;

    t_result     res;
    t_result     r_head, r_skid;
    logic        r_head_v, r_skid_v;
    logic        acc, push, pop;
    t_phase      end_phase;

    assign i_in.ready = !r_skid_v;
    assign acc  = i_in.valid && i_in.ready;
    assign push = acc && (i_in.op == OP_BYTE);
    assign pop  = r_head_v && o_out.ready;

    // Size table
    assign tbl_we    = acc && (i_in.op == OP_TABLE);
    assign tbl_waddr = i_in.table_tag[TAG_AW-1:0];
    assign tbl_raddr = n_tag[TAG_AW-1:0];

    tfp_ram #(
        .WIDTH (8),
        .DEPTH (TAG_COUNT)
    ) u_size_ram (
        .i_clk   (i_clk),
        .i_we    (tbl_we),
        .i_waddr (tbl_waddr),
        .i_wdata (i_in.table_size),
        .i_raddr (tbl_raddr),
        .o_rdata (ram_q)
    );

    assign expect_len = r_hit ? r_hit_data : (r_rvld ? ram_q : 8'd0);

    always_ff @(posedge i_clk) begin
        r_hit      <= tbl_we && (tbl_waddr == tbl_raddr);
        r_hit_data <= i_in.table_size;
        r_rvld     <= r_tvld[tbl_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < TAG_COUNT; i++) begin
                r_tvld[i] <= 1'b0;
            end
        end else if (tbl_we) begin
            r_tvld[tbl_waddr] <= 1'b1;
        end
    end

    // Parse step
    always_comb begin
        n_phase   = r_phase;
        n_tag     = r_tag;
        n_rem     = r_rem;
        n_cnt     = r_cnt;
        n_err     = r_err;
        end_phase = r_phase;
        res       = '0;
        res.byte_out = i_in.data_byte;
        if (push) begin
            unique case (r_phase)
                PH_VER: begin
                    res.byte_kind = PH_VER;
                    n_phase = PH_TAG;
                end
                PH_TAG: begin
                    res.byte_kind  = PH_TAG;
                    res.record_tag = i_in.data_byte;
                    n_tag   = i_in.data_byte;
                    n_phase = PH_LEN;
                end
                PH_LEN: begin
                    res.byte_kind  = PH_LEN;
                    res.record_tag = r_tag;
                    if (expect_len != 8'd0 && i_in.data_byte != expect_len) begin
                        n_err = 1'b1;
                    end
                    if (i_in.data_byte == 8'd0) begin
                        res.record_complete = 1'b1;
                        n_phase = PH_TAG;
                    end else begin
                        n_rem   = i_in.data_byte;
                        n_cnt   = 8'd0;
                        n_phase = PH_VAL;
                    end
                end
                PH_VAL: begin
                    res.byte_kind      = PH_VAL;
                    res.record_tag     = r_tag;
                    res.value_position = r_cnt;
                    n_cnt = r_cnt + 8'd1;
                    n_rem = r_rem - 8'd1;
                    if (r_rem == 8'd1) begin
                        res.record_complete = 1'b1;
                        n_phase = PH_TAG;
                    end
                end
                default: begin
                    // includes unused phase codes
                    res.byte_kind = PH_MSG;
                    n_phase = PH_VER;
                end
            endcase
            res.delivered  = !n_err;
            res.frame_done = i_in.frame_last;
            end_phase      = n_phase;
            if (i_in.frame_last) begin
                if (end_phase != PH_TAG) begin
                    res.frame_status = ST_FMT;
                end else if (n_err) begin
                    res.frame_status = ST_SIZE;
                end else begin
                    res.frame_status = ST_OK;
                end
                n_phase = PH_MSG;
                n_tag   = 8'd0;
                n_rem   = 8'd0;
                n_cnt   = 8'd0;
                n_err   = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_MSG;
            r_tag   <= 8'd0;
            r_rem   <= 8'd0;
            r_cnt   <= 8'd0;
            r_err   <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_tag   <= n_tag;
            r_rem   <= n_rem;
            r_cnt   <= n_cnt;
            r_err   <= n_err;
        end
    end

    // Output buffer: head register plus skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head_v <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (!r_head_v || pop) begin
            if (r_skid_v) begin
                r_head_v <= 1'b1;
                r_skid_v <= push;
            end else begin
                r_head_v <= push;
            end
        end else if (push) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_head_v || pop) begin
            if (r_skid_v) begin
                r_head <= r_skid;
                if (push) begin
                    r_skid <= res;
                end
            end else if (push) begin
                r_head <= res;
            end
        end else if (push) begin
            r_skid <= res;
        end
    end

    assign o_out.valid           = r_head_v;
    assign o_out.byte_kind       = r_head.byte_kind;
    assign o_out.byte_out        = r_head.byte_out;
    assign o_out.record_tag      = r_head.record_tag;
    assign o_out.value_position  = r_head.value_position;
    assign o_out.record_complete = r_head.record_complete;
    assign o_out.delivered       = r_head.delivered;
    assign o_out.frame_done      = r_head.frame_done;
    assign o_out.frame_status    = r_head.frame_status;

`ifndef ASSERT_OFF
    a_skid_needs_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_head_v)
        else $error("skid entry held without head entry");

    a_frame_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && i_in.frame_last) |=> (r_phase == PH_MSG && !r_err && r_tag == 8'd0))
        else $error("per-frame state not cleared at frame end");

    a_value_remaining: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_VAL) |-> (r_rem != 8'd0))
        else $error("value phase with no bytes remaining");

    a_status_only_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_head_v && r_head.frame_status != ST_OK) |-> r_head.frame_done)
        else $error("frame status reported before frame end");
`endif

endmodule
